// File: rtl/core/twqs_pkg.sv
// ----------------------------------------------------------------------------
// twqs_pkg
// Shared constants and types for the three-way quicksort engine.
// ----------------------------------------------------------------------------
package twqs_pkg;
    localparam int Capacity   = 1024;
    localparam int AddrBits   = $clog2(Capacity);
    localparam int CountBits  = AddrBits + 1;
    localparam int ValueBits  = 32;
    localparam int CutBits    = 11;
    localparam int StackDepth = 64;
    localparam int StackBits  = $clog2(StackDepth);
    localparam int LvlBits    = StackBits + 1;

    typedef logic [ValueBits-1:0] t_value;
    typedef logic [CountBits-1:0] t_count;

    // memory port requests from the sequencer
    typedef struct packed {
        logic   rd_en;
        t_count rd_addr;
        logic   wr_en;
        t_count wr_addr;
        t_value wr_data;
    } t_mem_req;
endpackage

// File: rtl/core/twqs_store.sv
// ----------------------------------------------------------------------------
// twqs_store
// Element store: one write and one registered read port.
// ----------------------------------------------------------------------------
module twqs_store (
    input  logic              i_clk,
    input  twqs_pkg::t_mem_req i_req,
    output twqs_pkg::t_value  o_rd_data
);
    import twqs_pkg::*;

    t_value r_mem [Capacity];
    t_value r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AddrBits-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[AddrBits-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: rtl/core/twqs_stack.sv
// ----------------------------------------------------------------------------
// twqs_stack
// Range stack: lo/hi pairs, push and pop, registered read of the top.
// ----------------------------------------------------------------------------
module twqs_stack (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [twqs_pkg::StackBits-1:0]    i_wr_addr,
    input  logic [2*twqs_pkg::CountBits-1:0]  i_wr_data,
    input  logic [twqs_pkg::StackBits-1:0]    i_rd_addr,
    output logic [2*twqs_pkg::CountBits-1:0]  o_rd_data
);
    import twqs_pkg::*;

    logic [2*CountBits-1:0] r_mem [StackDepth];
    logic [2*CountBits-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;
endmodule

// File: rtl/core/three_way_quicksort_engine.sv
// A load is written to the store as it is taken, unless the store is full; a read result passes
// the store's read register and then the output register. One load per cycle while idle and no
// result is waiting; a new read is not taken until the previous result has been taken. A last-
// element load starts the sort: a partition pass compares each element, a swap takes two writes
// (one write port on the store), insertion shifts larger elements up; no transfer is taken until it ends.
// Synchronous active-low reset clears counters and flags, sets cutoff to 16, leaves the store.
// ----------------------------------------------------------------------------
// three_way_quicksort_engine
// Loads values, sorts them in place by three-way quicksort and insertion sort, streams them.
// ----------------------------------------------------------------------------
module three_way_quicksort_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // element_value
    input  logic        s_axis_tuser,   // mode
    input  logic        s_axis_tlast,   // last_element
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // sorted_value, valid_res, overflowed, pad
    output logic        m_axis_tlast,   // final_value
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data      // insertion_cutoff
);
    import twqs_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0,  S_RDWAIT = 5'd1,  S_POP   = 5'd2,
                           S_POPW  = 5'd3,  S_RANGE  = 5'd4,  S_PIVW  = 5'd5,
                           S_PRD   = 5'd6,  S_PCMP   = 5'd7,  S_PSWR  = 5'd8,
                           S_PSW2  = 5'd9,  S_PDONE  = 5'd10, S_IOUT  = 5'd11,
                           S_IKEYW = 5'd12, S_IIN    = 5'd13, S_ICMP  = 5'd14,
                           S_INEXT = 5'd15, S_IJW    = 5'd16;

    logic [4:0]           r_st, n_st;
    t_count               r_cnt, r_rpos, r_lo, r_hi, r_cur, r_low, r_high, r_i, r_j;
    logic                 r_ovf, r_closed;
    logic [CutBits-1:0]   r_cut;
    logic [LvlBits-1:0]   r_lvl;
    t_value               r_piv, r_key, r_tmp;
    logic                 r_ov;
    logic [39:0]          r_od;
    logic                 r_ol;

    t_mem_req             w_req;
    t_value               w_rd;
    logic                 w_sw_en;
    logic [StackBits-1:0] w_sw_addr, w_sr_addr;
    logic [2*CountBits-1:0] w_sw_data, w_sr_data;

    twqs_store u_store (.i_clk(i_clk), .i_req(w_req), .o_rd_data(w_rd));
    twqs_stack u_stack (.i_clk(i_clk), .i_wr_en(w_sw_en), .i_wr_addr(w_sw_addr),
        .i_wr_data(w_sw_data), .i_rd_addr(w_sr_addr), .o_rd_data(w_sr_data));

    logic w_in_xfer, w_read, w_cfg_xfer;
    assign s_axis_tready = (r_st == S_IDLE) && !r_ov;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_read        = w_in_xfer && s_axis_tuser;
    assign o_cfg_ready   = (r_st == S_IDLE);
    assign w_cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tlast  = r_ol;

    t_count w_len, w_lt_len, w_gt_len, w_cnt_next;
    assign w_len    = r_hi - r_lo;
    assign w_lt_len = r_low - r_lo;
    assign w_gt_len = r_hi - r_high;
    assign w_sr_addr = r_lvl[StackBits-1:0] - 1'b1;
    // element count once the current load has been taken
    assign w_cnt_next = r_closed ? t_count'(1)
                      : (r_cnt < t_count'(Capacity)) ? r_cnt + 1'b1 : r_cnt;

    always_comb begin
        n_st      = r_st;
        w_req     = '0;
        w_sw_en   = 1'b0;
        w_sw_addr = r_lvl[StackBits-1:0];
        w_sw_data = '0;
        case (r_st)
            S_IDLE: begin
                if (w_in_xfer && !s_axis_tuser) begin
                    w_req.wr_en   = !(r_closed ? 1'b0 : (r_cnt >= t_count'(Capacity)));
                    w_req.wr_addr = r_closed ? '0 : r_cnt;
                    w_req.wr_data = s_axis_tdata;
                    if (s_axis_tlast) begin
                        // seed the stack with the whole set
                        w_sw_en   = 1'b1;
                        w_sw_data = {t_count'(0), w_cnt_next};
                        n_st      = S_POP;
                    end
                end else if (w_read) begin
                    w_req.rd_en   = 1'b1;
                    w_req.rd_addr = r_rpos;
                    n_st = S_RDWAIT;
                end
            end
            S_RDWAIT: n_st = S_IDLE;
            S_POP:  n_st = (r_lvl == '0) ? S_IDLE : S_POPW;
            S_POPW: n_st = S_RANGE;
            S_RANGE: begin
                if (w_len > t_count'(r_cut)) begin
                    w_req.rd_en = 1'b1; w_req.rd_addr = r_lo; n_st = S_PIVW;
                end else begin
                    n_st = S_IOUT;
                end
            end
            S_PIVW: n_st = S_PRD;
            S_PRD: begin
                if (r_cur < r_high) begin
                    w_req.rd_en = 1'b1; w_req.rd_addr = r_cur; n_st = S_PCMP;
                end else begin
                    n_st = S_PDONE;
                end
            end
            S_PCMP: begin
                // value at cur is on w_rd
                if (w_rd < r_piv) begin
                    w_req.rd_en = 1'b1; w_req.rd_addr = r_low; n_st = S_PSWR;
                end else if (w_rd > r_piv) begin
                    w_req.rd_en = 1'b1; w_req.rd_addr = r_high - 1'b1; n_st = S_PSWR;
                end else begin
                    n_st = S_PRD;
                end
            end
            S_PSWR: begin
                // partner value arrives; write held cur value to partner slot
                w_req.wr_en   = 1'b1;
                w_req.wr_addr = r_i;
                w_req.wr_data = r_key;
                n_st = S_PSW2;
            end
            S_PSW2: begin
                w_req.wr_en = 1'b1; w_req.wr_addr = r_cur; w_req.wr_data = r_tmp;
                n_st = S_PRD;
            end
            S_PDONE: begin
                w_sw_en = (r_lvl < LvlBits'(StackDepth));
                w_sw_data = (w_lt_len <= w_gt_len) ? {r_high, r_hi} : {r_lo, r_low};
                n_st = S_RANGE;
            end
            S_IOUT: begin
                if (r_i < r_hi) begin
                    w_req.rd_en = 1'b1; w_req.rd_addr = r_i; n_st = S_IKEYW;
                end else begin
                    n_st = S_POP;
                end
            end
            S_IKEYW: n_st = S_IIN;
            S_IIN: begin
                if (r_j > r_lo) begin
                    w_req.rd_en = 1'b1; w_req.rd_addr = r_j - 1'b1; n_st = S_IJW;
                end else begin
                    n_st = S_INEXT;
                end
            end
            S_IJW: n_st = S_ICMP;
            S_ICMP: begin
                if (r_tmp > r_key) begin
                    w_req.wr_en = 1'b1; w_req.wr_addr = r_j; w_req.wr_data = r_tmp;
                    n_st = S_IIN;
                end else begin
                    n_st = S_INEXT;
                end
            end
            S_INEXT: begin
                w_req.wr_en = 1'b1; w_req.wr_addr = r_j; w_req.wr_data = r_key;
                n_st = S_IOUT;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_rpos <= '0; r_ovf <= 1'b0;
            r_closed <= 1'b0; r_cut <= CutBits'(16); r_lvl <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_cfg_xfer) r_cut <= i_cfg_data;
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (w_in_xfer && !s_axis_tuser) begin
                        if (r_closed) begin
                            r_cnt <= t_count'(1); r_ovf <= 1'b0; r_rpos <= '0;
                            r_closed <= 1'b0;
                        end else if (r_cnt < t_count'(Capacity)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_lvl <= LvlBits'(1);
                        end
                    end
                end
                S_RDWAIT: begin
                    r_ov <= 1'b1;
                    if (r_closed && r_rpos < r_cnt) begin
                        r_od <= {6'd0, r_ovf, 1'b1, w_rd};
                        r_ol <= (r_rpos + 1'b1 == r_cnt);
                        r_rpos <= r_rpos + 1'b1;
                    end else begin
                        r_od <= {6'd0, r_ovf, 1'b0, 32'd0};
                        r_ol <= 1'b0;
                    end
                end
                S_POP: begin
                    if (r_lvl == '0) begin
                        r_closed <= 1'b1; r_rpos <= '0;
                    end
                end
                S_POPW: begin
                    r_lvl <= r_lvl - 1'b1;
                    r_lo <= w_sr_data[2*CountBits-1:CountBits];
                    r_hi <= w_sr_data[CountBits-1:0];
                    r_i <= '0;
                end
                S_RANGE: begin
                    r_cur <= r_lo; r_low <= r_lo; r_high <= r_hi;
                    r_i <= r_lo + 1'b1;
                end
                S_PIVW: r_piv <= w_rd;
                S_PCMP: begin
                    r_key <= w_rd;
                    if (w_rd < r_piv) begin
                        r_i <= r_low;
                    end else if (w_rd > r_piv) begin
                        r_i <= r_high - 1'b1; r_high <= r_high - 1'b1;
                    end else begin
                        r_cur <= r_cur + 1'b1;
                    end
                end
                S_PSWR: begin
                    r_tmp <= w_rd;
                end
                S_PSW2: begin
                    if (r_i == r_low && r_i != r_high) begin
                        r_low <= r_low + 1'b1; r_cur <= r_cur + 1'b1;
                    end
                end
                S_PDONE: begin
                    if (r_lvl < LvlBits'(StackDepth)) r_lvl <= r_lvl + 1'b1;
                    if (w_lt_len <= w_gt_len) r_hi <= r_low;
                    else r_lo <= r_high;
                end
                S_IKEYW: ;
                S_IIN: if (r_j == r_i) r_key <= w_rd;
                S_IJW: ;
                S_ICMP: if (r_tmp > r_key) r_j <= r_j - 1'b1;
                S_INEXT: begin
                    r_i <= r_i + 1'b1;
                end
                S_IOUT: r_j <= r_i;
                default: ;
            endcase
            if (r_st == S_IJW) r_tmp <= w_rd;
            if (r_st == S_IKEYW) r_key <= w_rd;
        end
    end
endmodule

// File: tb/three_way_quicksort_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_way_quicksort_engine_tb
// Loads value sets, closes each with the last mark, then reads it back. The
// reads are checked against a sorted copy kept alongside the engine. Covers
// cutoff extremes, duplicates, reads before close and past the count,
// stalls and idle gaps on both streams.
// ----------------------------------------------------------------------------
module three_way_quicksort_engine_tb;
    import twqs_pkg::*;

    localparam int  HalfPeriod = 2;
    localparam int  CycleLimit = 6000000;
    localparam int unsigned HoldOffLen = 400;
    localparam bit  ModeLoad   = 1'b0;
    localparam bit  ModeRead   = 1'b1;

    typedef struct {
        t_value value;
        logic   ok;
        logic   fin;
        logic   ovf;
    } t_sorted_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // element_value
    logic        s_axis_tuser = 1'b0; // mode
    logic        s_axis_tlast = 1'b0; // last_element
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // sorted_value, valid_res, overflowed, pad
    logic        m_axis_tlast;        // final_value
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data = '0;     // insertion_cutoff

    // engine state as the testbench sees it
    t_value       set_values[$];
    t_value       sorted_set[$];
    int unsigned  read_pos;
    bit           set_closed;
    bit           ovf_flag;
    t_sorted_beat pending_beats[$];

    int unsigned  fail_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  items_sent;
    int unsigned  src_idle_pct;
    int unsigned  snk_stall_pct;
    bit           hold_off_req = 1'b0;
    bit           hold_off_seen = 1'b0;
    int unsigned  hold_off_cycles = 0;

    three_way_quicksort_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #HalfPeriod i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("three_way_quicksort_engine_tb failed");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off counted down here
    always @(posedge i_clk) begin
        if (hold_off_req != hold_off_seen) begin
            hold_off_seen   <= hold_off_req;
            hold_off_cycles <= HoldOffLen;
            m_axis_tready   <= 1'b0;
        end else if (hold_off_cycles != 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready   <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    endtask

    always @(posedge i_clk) begin
        t_sorted_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected transfer", m_axis_tdata[31:0], '0);
            end else begin
                want = pending_beats.pop_front();
                if (m_axis_tdata[31:0] !== want.value)
                    report_mismatch("sorted_value", m_axis_tdata[31:0], want.value);
                if (m_axis_tdata[32] !== want.ok)
                    report_mismatch("valid_res", 32'(m_axis_tdata[32]), 32'(want.ok));
                if (m_axis_tdata[33] !== want.ovf)
                    report_mismatch("overflowed", 32'(m_axis_tdata[33]), 32'(want.ovf));
                if (m_axis_tlast !== want.fin)
                    report_mismatch("final_value", 32'(m_axis_tlast), 32'(want.fin));
            end
        end
    end

    // advance the shadow state by one accepted transfer
    task automatic track_transfer(input logic mode, input t_value value, input logic last);
        t_sorted_beat beat;
        if (mode == ModeLoad) begin
            if (set_closed) begin
                set_values.delete();
                read_pos   = 0;
                ovf_flag   = 1'b0;
                set_closed = 1'b0;
            end
            if (set_values.size() < Capacity) set_values.push_back(value);
            else ovf_flag = 1'b1;
            if (last) begin
                sorted_set = set_values;
                sorted_set.sort();
                read_pos   = 0;
                set_closed = 1'b1;
            end
        end else begin
            beat = '{value: '0, ok: 1'b0, fin: 1'b0, ovf: ovf_flag};
            if (set_closed && read_pos < sorted_set.size()) begin
                beat.value = sorted_set[read_pos];
                beat.ok    = 1'b1;
                beat.fin   = (read_pos + 1 == sorted_set.size());
                read_pos++;
            end
            pending_beats.push_back(beat);
        end
    endtask

    task automatic send_item(input logic mode, input t_value value, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        track_transfer(mode, value, last);
        items_sent++;
    endtask

    // drain results and let any sort finish before touching the register
    task automatic wait_idle();
        int unsigned quiet;
        quiet = 0;
        s_axis_tvalid <= 1'b0;
        while (quiet < 8) begin
            @(posedge i_clk);
            if (pending_beats.size() == 0 && s_axis_tready) quiet++;
            else quiet = 0;
        end
    endtask

    task automatic write_cutoff(input logic [10:0] cut);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cut;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid   <= 1'b0;
    endtask

    function automatic t_value pick_value(input int unsigned spread);
        case (spread)
            0:       return t_value'($urandom_range(3));
            1:       return t_value'($urandom_range(40));
            2:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    task automatic load_and_read(input int unsigned n, input int unsigned spread,
                                 input int unsigned extra_reads);
        for (int unsigned k = 0; k < n; k++)
            send_item(ModeLoad, pick_value(spread), k == n - 1);
        for (int unsigned k = 0; k < n + extra_reads; k++)
            send_item(ModeRead, $urandom, 1'($urandom_range(1)));
    endtask

    task automatic test_directed();
        // read before any set is closed
        send_item(ModeRead, 32'h1234_5678, 1'b0);
        // single element set, then read past its count
        send_item(ModeLoad, 32'hFFFF_FFFF, 1'b1);
        send_item(ModeRead, '0, 1'b0);
        send_item(ModeRead, '0, 1'b1);
        // extremes and duplicates; a read before the last mark
        send_item(ModeLoad, 32'h0000_0000, 1'b0);
        send_item(ModeLoad, 32'hFFFF_FFFF, 1'b0);
        send_item(ModeRead, '0, 1'b0);
        send_item(ModeLoad, 32'h8000_0000, 1'b0);
        send_item(ModeLoad, 32'h0000_0000, 1'b0);
        send_item(ModeLoad, 32'h7FFF_FFFF, 1'b0);
        send_item(ModeLoad, 32'hFFFF_FFFF, 1'b1);
        for (int k = 0; k < 7; k++) send_item(ModeRead, $urandom, 1'b0);
        // load after close starts a fresh set
        send_item(ModeLoad, 32'h5555_AAAA, 1'b0);
        send_item(ModeLoad, 32'hAAAA_5555, 1'b1);
        for (int k = 0; k < 3; k++) send_item(ModeRead, '0, 1'b0);
    endtask

    task automatic test_cutoff_extremes();
        logic [10:0] cuts[5] = '{11'd0, 11'd1, 11'd1024, 11'd2047, 11'd3};
        foreach (cuts[c]) begin
            write_cutoff(cuts[c]);
            load_and_read(2 + $urandom_range(30), c % 4, 1);
        end
        write_cutoff(11'd16);
    endtask

    task automatic test_backpressure();
        wait_idle();
        load_and_read(40, 1, 0);
        wait_idle();
        hold_off_req = ~hold_off_req;
        for (int k = 0; k < 60; k++) send_item(ModeRead, '0, 1'b0);
    endtask

    task automatic test_random(input int unsigned quota);
        int unsigned idle_phase[4] = '{0, 72, 0, 35};
        int unsigned stall_phase[4] = '{0, 0, 72, 35};
        int unsigned target;
        for (int p = 0; p < 4; p++) begin
            write_cutoff(11'($urandom_range(40)));
            src_idle_pct  = idle_phase[p];
            snk_stall_pct = stall_phase[p];
            target = items_sent + quota / 4;
            while (items_sent < target) begin
                if ($urandom_range(9) == 0) begin
                    // noise: stray read or an unfinished load
                    send_item(1'($urandom_range(1)), $urandom, 1'b0);
                end else begin
                    load_and_read(1 + $urandom_range(24), $urandom_range(3),
                                  $urandom_range(2));
                end
            end
        end
        src_idle_pct  = 0;
        snk_stall_pct = 0;
    endtask

    initial begin
        items_sent      = 0;
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        read_pos        = 0;
        set_closed      = 1'b0;
        ovf_flag        = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_cutoff_extremes();
        test_backpressure();
        test_random(160);

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_beats.size() == 0) begin
            $display("three_way_quicksort_engine_tb passed");
        end else begin
            $display("three_way_quicksort_engine_tb failed");
        end
        $finish;
    end
endmodule
